### rtl/core/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int DATA_W          = 32;
   localparam int CAP_W           = 5;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
   localparam logic              OP_GET     = 1'b0;
   localparam logic              OP_PUT     = 1'b1;
   localparam logic              REG_CAPACITY = 1'b0;
   localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic                     op;
      logic signed [DATA_W-1:0] lookup_key;
      logic signed [DATA_W-1:0] store_value;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic signed [DATA_W-1:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } entry_type;

   // update strobe and case flags broadcast to every cell
   typedef struct packed {
      logic upd;
      logic any_hit;
      logic full;
   } cell_ctl_type;

endpackage
`default_nettype wire

### rtl/core/lkvc_cell.sv
// One recency-ordered cache entry: tag compare and shift from its younger neighbor.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_cell (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic signed [lkvc_pkg::DATA_W-1:0]   lookup_key,
   input  wire lkvc_pkg::cell_ctl_type               ctl,
   input  wire lkvc_pkg::entry_type                  shift_in,
   input  wire logic                                 hit_tail_in,
   output lkvc_pkg::entry_type                       entry_out,
   output logic                                      hit,
   output logic                                      hit_tail_out
);

   logic                            valid_ff;
   logic signed [lkvc_pkg::DATA_W-1:0] key_ff;
   logic signed [lkvc_pkg::DATA_W-1:0] value_ff;
   logic                            load_in;

   assign hit          = valid_ff && (key_ff == lookup_key);
   assign hit_tail_out = hit | hit_tail_in;

   // hit: cells up to the hit entry move down; full: all valid cells move,
   // the oldest drops out; room: valid cells plus the first free one move
   always_comb begin
      if (ctl.any_hit) begin
         load_in = ctl.upd && hit_tail_out;
      end else if (ctl.full) begin
         load_in = ctl.upd && valid_ff;
      end else begin
         load_in = ctl.upd && shift_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_in) begin
         valid_ff <= shift_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         key_ff   <= shift_in.key;
         value_ff <= shift_in.value;
      end
   end

   assign entry_out.valid = valid_ff;
   assign entry_out.key   = key_ff;
   assign entry_out.value = value_ff;

endmodule
`default_nettype wire

### rtl/core/lru_key_value_cache.sv
// Top level of the LRU key/value cache: request register, cell chain, response register.
// A get's response passes through the request register and then the response register.
// Throughput: one request per cycle while req_stall is low; the request register and the response
// register let a new request enter while a response waits.
// Each put or get hit updates the cell chain by shifting entries in recency order.
// Reset: synchronous, active high; clears all entries and sets capacity to 16.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire lkvc_pkg::req_type                   req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output lkvc_pkg::rsp_type                        rsp_payload,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [lkvc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [lkvc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lkvc_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

   logic [lkvc_pkg::CAP_W-1:0]  capacity_ff;
   logic [CNT_W-1:0]            count_ff;
   logic                        pend_valid_ff;
   lkvc_pkg::req_type           pend_ff;
   logic                        rsp_valid_ff;
   lkvc_pkg::rsp_type           rsp_ff;

   lkvc_pkg::entry_type         cell_entry [MAX_ENTRIES];
   lkvc_pkg::entry_type         front_entry;
   logic [MAX_ENTRIES-1:0]      cell_hit;
   logic [MAX_ENTRIES:0]        hit_tail;
   lkvc_pkg::cell_ctl_type      ctl;

   logic                        fire;
   logic                        is_put;
   logic                        any_hit;
   logic signed [lkvc_pkg::DATA_W-1:0] hit_value;
   logic [CMP_W-1:0]            cap_ext;
   logic [CMP_W-1:0]            eff_cap;
   logic                        full;
   logic                        csr_wr;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkvc_pkg::CAP_RESET;
      end else if (csr_wr && (csr_paddr[2] == lkvc_pkg::REG_CAPACITY)) begin
         capacity_ff <= csr_pwdata[lkvc_pkg::CAP_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == lkvc_pkg::REG_CAPACITY) begin
         csr_prdata = lkvc_pkg::CSR_DATA_W'(capacity_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // effective capacity clamped to 1 .. MAX_ENTRIES
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign full = (CMP_W'(count_ff) >= eff_cap);

   // request register
   assign is_put    = (pend_ff.op == lkvc_pkg::OP_PUT);
   assign fire      = pend_valid_ff && (is_put || !rsp_valid_ff || !rsp_stall);
   assign req_stall = pend_valid_ff && !fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         pend_valid_ff <= 1'b1;
      end else if (fire) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         pend_ff <= req_payload;
      end
   end

   // cell chain, index 0 is the most recent entry
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (cell_hit[i]) begin
            hit_value = hit_value | cell_entry[i].value;
         end
      end
   end

   assign any_hit           = hit_tail[0];
   assign hit_tail[MAX_ENTRIES] = 1'b0;
   assign front_entry.valid = 1'b1;
   assign front_entry.key   = pend_ff.lookup_key;
   assign front_entry.value = is_put ? pend_ff.store_value : hit_value;

   assign ctl.upd     = fire && (is_put || any_hit);
   assign ctl.any_hit = any_hit;
   assign ctl.full    = full;

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      lkvc_pkg::entry_type shift_in;
      if (g == 0) begin : g_head
         assign shift_in = front_entry;
      end else begin : g_body
         assign shift_in = cell_entry[g-1];
      end
      lkvc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .lookup_key   (pend_ff.lookup_key),
         .ctl          (ctl),
         .shift_in     (shift_in),
         .hit_tail_in  (hit_tail[g+1]),
         .entry_out    (cell_entry[g]),
         .hit          (cell_hit[g]),
         .hit_tail_out (hit_tail[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire && is_put && !any_hit && !full) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && !is_put) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && !is_put) begin
         rsp_ff.found      <= any_hit;
         rsp_ff.read_value <= any_hit ? hit_value : lkvc_pkg::MISS_VALUE;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
